### rtl/dhop_pkg.sv
// Shared types and constants for the DHCPv6 header and option walker.
// Used by the top level and by the port checker. No dependencies.
`default_nettype none

package dhop_pkg;

    // Byte count of the link and peer address fields of a relay header.
    localparam int unsigned ADDRESS_BYTES = 16;

    // Header field sizes that follow the message type.
    localparam int unsigned HOP_BYTES = 1;
    localparam int unsigned XID_BYTES = 3;

    // Fixed option header size added per option to the byte total.
    localparam int unsigned OPT_HDR_BYTES = 4;

    // Message types that carry a relay header.
    localparam logic [7:0] MSG_RELAY_FORW = 8'd12;
    localparam logic [7:0] MSG_RELAY_REPL = 8'd13;

    // Region tags reported with each byte.
    typedef enum logic [2:0] {
        RGN_TYPE      = 3'd0,
        RGN_HOP_XID   = 3'd1,
        RGN_LINK_ADDR = 3'd2,
        RGN_PEER_ADDR = 3'd3,
        RGN_OPT_CODE  = 3'd4,
        RGN_OPT_LEN   = 3'd5,
        RGN_OPT_DATA  = 3'd6
    } region_t;

endpackage

`default_nettype wire

### rtl/dhcpv6_header_option_parser.sv
// Top level of the DHCPv6 header and option walker; depends on dhop_pkg.
// Path: with no stall, a request is captured in the input register, parsed as it
// leaves it, and its result is held in the output register until it is taken.
// Throughput: one request per cycle, back to back; stall reaches the input
// only when both the input and the output register are full and out_stall is high.
// Reset (rst_n low, asynchronous) empties both stages and clears the parser.
`default_nettype none

module dhcpv6_header_option_parser
    import dhop_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_message,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       region,
    output logic [15:0]      region_offset,
    output logic             is_relay,
    output logic [15:0]      current_option_code,
    output logic [15:0]      current_option_length,
    output logic [7:0]       options_seen,
    output logic [15:0]      options_total_bytes,
    output logic             malformed,
    output logic             message_done
);

    // ------------------------------------------------------------------
    // Input register. It holds one request until the parse step below can
    // hand its result to the output register.
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // The parse step fires when a request sits in the input register and
    // the output register is empty or is being emptied in this cycle.
    logic out_free;
    logic advance;

    assign out_free = !out_valid || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
            last_reg <= end_of_message;
        end
    end

    // ------------------------------------------------------------------
    // Parser state. It changes only when a request leaves the input
    // register, so it always describes the byte that is next in line.
    // ------------------------------------------------------------------
    region_t     parse_region_reg, parse_region_next;
    logic [15:0] byte_index_reg, byte_index_next;
    logic        relay_flag_reg, relay_flag_next;
    logic [15:0] option_code_reg, option_code_next;
    logic [15:0] option_length_reg, option_length_next;
    logic [7:0]  option_counter_reg, option_counter_next;
    logic [15:0] option_total_reg, option_total_next;

    // Values reported with the current byte.
    region_t     cur_region;
    logic        bad;

    logic [16:0] off_inc;
    logic [17:0] total_sum;
    logic [15:0] len_full;

    assign off_inc   = {1'b0, byte_index_reg} + 17'd1;
    assign len_full  = {option_length_reg[7:0], byte_reg};
    assign total_sum = {2'b00, option_total_reg} + {2'b00, len_full}
                     + 18'(OPT_HDR_BYTES);

    always_comb
    begin
        parse_region_next   = parse_region_reg;
        byte_index_next     = off_inc[15:0];
        relay_flag_next     = relay_flag_reg;
        option_code_next    = option_code_reg;
        option_length_next  = option_length_reg;
        option_counter_next = option_counter_reg;
        option_total_next   = option_total_reg;
        cur_region          = parse_region_reg;

        case (parse_region_reg)
            RGN_HOP_XID:
            begin
                if (off_inc >= (relay_flag_reg ? 17'(HOP_BYTES) : 17'(XID_BYTES)))
                begin
                    parse_region_next = relay_flag_reg ? RGN_LINK_ADDR : RGN_OPT_CODE;
                    byte_index_next   = '0;
                end
            end
            RGN_LINK_ADDR:
            begin
                if (off_inc >= 17'(ADDRESS_BYTES))
                begin
                    parse_region_next = RGN_PEER_ADDR;
                    byte_index_next   = '0;
                end
            end
            RGN_PEER_ADDR:
            begin
                if (off_inc >= 17'(ADDRESS_BYTES))
                begin
                    parse_region_next = RGN_OPT_CODE;
                    byte_index_next   = '0;
                end
            end
            RGN_OPT_CODE:
            begin
                if (byte_index_reg == '0)
                begin
                    option_code_next   = {8'h00, byte_reg};
                    option_length_next = '0;
                end
                else
                begin
                    option_code_next  = {option_code_reg[7:0], byte_reg};
                    parse_region_next = RGN_OPT_LEN;
                    byte_index_next   = '0;
                end
            end
            RGN_OPT_LEN:
            begin
                if (byte_index_reg == '0)
                begin
                    option_length_next = {8'h00, byte_reg};
                end
                else
                begin
                    // The option header is now complete: count it and add
                    // its full size to the running total, both saturating.
                    option_length_next = len_full;
                    if (option_counter_reg != 8'hFF)
                    begin
                        option_counter_next = option_counter_reg + 8'd1;
                    end
                    option_total_next = (total_sum[17:16] != 2'b00) ? 16'hFFFF
                                                                    : total_sum[15:0];
                    // An empty option goes straight on to the next code.
                    parse_region_next = (len_full == '0) ? RGN_OPT_CODE : RGN_OPT_DATA;
                    byte_index_next   = '0;
                end
            end
            RGN_OPT_DATA:
            begin
                if (off_inc >= {1'b0, option_length_reg})
                begin
                    parse_region_next = RGN_OPT_CODE;
                    byte_index_next   = '0;
                end
            end
            default:
            begin
                // Message type byte, and the recovery path for any code
                // that is not a region.
                cur_region        = RGN_TYPE;
                relay_flag_next   = (byte_reg inside {MSG_RELAY_FORW, MSG_RELAY_REPL});
                parse_region_next = RGN_HOP_XID;
                byte_index_next   = '0;
            end
        endcase

        // A message is well formed only if it stops exactly at an option
        // boundary, which is also where the header hands over to options.
        bad = last_reg && !(parse_region_next == RGN_OPT_CODE && byte_index_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_region_reg   <= RGN_TYPE;
            byte_index_reg     <= '0;
            relay_flag_reg     <= 1'b0;
            option_code_reg    <= '0;
            option_length_reg  <= '0;
            option_counter_reg <= '0;
            option_total_reg   <= '0;
        end
        else if (advance)
        begin
            if (last_reg)
            begin
                // The final byte closes the message; start over.
                parse_region_reg   <= RGN_TYPE;
                byte_index_reg     <= '0;
                relay_flag_reg     <= 1'b0;
                option_code_reg    <= '0;
                option_length_reg  <= '0;
                option_counter_reg <= '0;
                option_total_reg   <= '0;
            end
            else
            begin
                parse_region_reg   <= parse_region_next;
                byte_index_reg     <= byte_index_next;
                relay_flag_reg     <= relay_flag_next;
                option_code_reg    <= option_code_next;
                option_length_reg  <= option_length_next;
                option_counter_reg <= option_counter_next;
                option_total_reg   <= option_total_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register. It keeps its result while out_stall is high.
    // ------------------------------------------------------------------
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    logic [2:0]  region_reg;
    logic [15:0] offset_reg;
    logic        relay_reg;
    logic [15:0] code_reg;
    logic [15:0] length_reg;
    logic [7:0]  seen_reg;
    logic [15:0] total_reg;
    logic        bad_reg;
    logic        done_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            region_reg <= cur_region;
            offset_reg <= byte_index_reg;
            relay_reg  <= relay_flag_next;
            code_reg   <= option_code_next;
            length_reg <= option_length_next;
            seen_reg   <= option_counter_next;
            total_reg  <= option_total_next;
            bad_reg    <= bad;
            done_reg   <= last_reg;
        end
    end

    assign out_valid             = out_valid_reg;
    assign region                = region_reg;
    assign region_offset         = offset_reg;
    assign is_relay              = relay_reg;
    assign current_option_code   = code_reg;
    assign current_option_length = length_reg;
    assign options_seen          = seen_reg;
    assign options_total_bytes   = total_reg;
    assign malformed             = bad_reg;
    assign message_done          = done_reg;

endmodule

`default_nettype wire

### rtl/dhop_checker.sv
// Port-level checker for the DHCPv6 header and option walker, and the bind
// that attaches it to the top level. Depends on dhop_pkg.
`default_nettype none

module dhop_checker
    import dhop_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  region,
    input wire logic [15:0] region_offset,
    input wire logic        is_relay,
    input wire logic [15:0] options_total_bytes,
    input wire logic        malformed,
    input wire logic        message_done
);

    // A stalled result stays put until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(region)
            && $stable(region_offset) && $stable(options_total_bytes))
        else $error("result changed while stalled");

    // Malformed is only reported on the byte that closes a message.
    a_bad_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && malformed |-> message_done)
        else $error("malformed flagged before end of message");

    // The type byte is always the first and only byte of its region.
    a_type_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && region == RGN_TYPE |-> region_offset == '0)
        else $error("type byte with nonzero offset");

    // Address regions exist only in relay messages.
    a_addr_relay: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (region == RGN_LINK_ADDR || region == RGN_PEER_ADDR)
            |-> is_relay)
        else $error("address region in a non-relay message");

    // A closed message makes the next result start with a type byte.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && message_done ##1 out_valid
            |-> region == RGN_TYPE)
        else $error("message did not restart at type byte");

endmodule

bind dhcpv6_header_option_parser dhop_checker u_dhop_checker (.*);

`default_nettype wire
